[src/pgu_pkg.sv]
package pgu_pkg;

    // Register indexes of the configuration port
    localparam logic [7:0] CFG_VOLUME   = 8'd0;
    localparam logic [7:0] CFG_WIDE     = 8'd1;
    localparam logic [7:0] CFG_STEREO   = 8'd2;
    localparam logic [7:0] CFG_UPSAMPLE = 8'd3;

    // Reset values of the registers
    localparam logic [9:0] VOLUME_RST   = 10'd256;
    localparam logic       WIDE_RST     = 1'b1;
    localparam logic       STEREO_RST   = 1'b1;
    localparam logic       UPSAMPLE_RST = 1'b0;

    // Round-toward-zero bias for the divide by 256
    localparam logic [27:0] DIV256_BIAS = 28'd255;

    typedef struct packed {
        logic [9:0] volume;
        logic       wide;
        logic       stereo;
        logic       upsample;
    } t_cfg;

    // One queued frame: midpoint and converted samples plus what to emit
    typedef struct packed {
        logic [15:0] mid_l;
        logic [15:0] mid_r;
        logic [15:0] cur_l;
        logic [15:0] cur_r;
        logic        has_mid;
        logic        has_tail;
    } t_qent;

    // Which result of a frame the back end is emitting
    typedef enum logic [1:0] {
        PH_MID,
        PH_MAIN,
        PH_TAIL
    } t_phase;

endpackage

[src/pgu_front.sv]
module pgu_front
    import pgu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_left_code,
    input  logic [15:0] i_right_code,
    input  logic        i_final,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_qent       o_q_data
);

    // Stage A: operand select
    logic               r_a_vld;
    logic signed [16:0] r_a_l, r_a_r;
    logic               r_a_fin;
    // Stage B: products
    logic               r_b_vld;
    logic signed [27:0] r_b_pl, r_b_pr;
    logic               r_b_fin;
    // Stage C: converted samples
    logic               r_c_vld;
    logic [15:0]        r_c_l, r_c_r;
    logic               r_c_fin;
    // Stream state
    logic [15:0]        r_prev_l, r_prev_r;
    logic               r_seen;

    logic               adv;
    logic signed [16:0] n_a_l, n_a_r;
    logic signed [10:0] vol_s;
    logic [15:0]        n_c_l, n_c_r;

    // 8-bit offset binary minus 128 is the code with its top bit flipped
    function automatic logic signed [16:0] sel_operand(input logic [15:0] code,
                                                      input logic wide);
        logic [7:0] ob;
        ob = {~code[7], code[6:0]};
        if (wide) begin
            sel_operand = {code[15], code};
        end else begin
            sel_operand = {{9{ob[7]}}, ob};
        end
    endfunction

    // Scale result: divide by 256 toward zero in wide mode, then wrap
    function automatic logic [15:0] scale(input logic signed [27:0] p, input logic wide);
        logic [27:0] t;
        t = p[27] ? (28'(p) + DIV256_BIAS) : 28'(p);
        if (wide) begin
            scale = t[23:8];
        end else begin
            scale = p[15:0];
        end
    endfunction

    // Midpoint cur - (cur - prev) / 2, halving truncated toward zero
    function automatic logic [15:0] midpoint(input logic [15:0] c, input logic [15:0] p);
        logic signed [16:0] d;
        logic signed [16:0] h;
        logic signed [16:0] m;
        d = {c[15], c} - {p[15], p};
        h = (d + 17'(d[16])) >>> 1;
        m = {c[15], c} - h;
        midpoint = m[15:0];
    endfunction

    assign adv     = !r_c_vld || !i_q_full;
    assign o_ready = adv;

    always_comb begin
        n_a_l = sel_operand(i_left_code, i_cfg.wide);
        n_a_r = i_cfg.stereo ? sel_operand(i_right_code, i_cfg.wide) : 17'sd0;
        vol_s = signed'({1'b0, i_cfg.volume});
        n_c_l = scale(r_b_pl, i_cfg.wide);
        n_c_r = scale(r_b_pr, i_cfg.wide);
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_l   <= n_a_l;
            r_a_r   <= n_a_r;
            r_a_fin <= i_final;
            r_b_pl  <= 28'(r_a_l * vol_s);
            r_b_pr  <= 28'(r_a_r * vol_s);
            r_b_fin <= r_a_fin;
            r_c_l   <= n_c_l;
            r_c_r   <= n_c_r;
            r_c_fin <= r_b_fin;
        end
    end

    // Queue entry
    assign o_q_push = adv && r_c_vld;
    always_comb begin
        o_q_data.cur_l    = r_c_l;
        o_q_data.cur_r    = i_cfg.stereo ? r_c_r : 16'd0;
        o_q_data.mid_l    = midpoint(r_c_l, r_prev_l);
        o_q_data.mid_r    = i_cfg.stereo ? midpoint(r_c_r, r_prev_r) : 16'd0;
        o_q_data.has_mid  = i_cfg.upsample && r_seen;
        o_q_data.has_tail = i_cfg.upsample && r_c_fin;
    end

    // Previous frame; a final frame ends the stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= 16'd0;
            r_prev_r <= 16'd0;
            r_seen   <= 1'b0;
        end else if (o_q_push) begin
            if (r_c_fin) begin
                r_prev_l <= 16'd0;
                r_prev_r <= 16'd0;
                r_seen   <= 1'b0;
            end else begin
                r_prev_l <= r_c_l;
                r_prev_r <= o_q_data.cur_r;
                r_seen   <= 1'b1;
            end
        end
    end

endmodule

[src/pgu_fifo.sv]
module pgu_fifo
    import pgu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_qent o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_qent            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/pgu_back.sv]
module pgu_back
    import pgu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_qent       i_q_data,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_left,
    output logic [15:0] o_right,
    output logic        o_last
);

    t_phase      r_phase, n_phase;
    t_phase      eff;
    logic        r_valid;
    logic [15:0] r_left, r_right;
    logic        r_last;
    logic        load;
    logic        done;
    logic [15:0] sel_l, sel_r;
    logic        sel_last;

    assign load = i_q_valid && (!r_valid || i_ready);

    // Skip the midpoint phase when the frame has none
    always_comb begin
        eff = (r_phase == PH_MID && !i_q_data.has_mid) ? PH_MAIN : r_phase;
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        done    = 1'b0;
        case (eff)
            PH_MID:  n_phase = PH_MAIN;
            PH_MAIN: begin
                if (i_q_data.has_tail) begin
                    n_phase = PH_TAIL;
                end else begin
                    n_phase = PH_MID;
                    done    = 1'b1;
                end
            end
            PH_TAIL: begin
                n_phase = PH_MID;
                done    = 1'b1;
            end
            default: n_phase = PH_MID;
        endcase
        if (!load) begin
            n_phase = r_phase;
            done    = 1'b0;
        end
    end

    // Result selection per phase
    always_comb begin
        sel_l    = 16'd0;
        sel_r    = 16'd0;
        sel_last = 1'b1;
        case (eff)
            PH_MID: begin
                sel_l    = i_q_data.mid_l;
                sel_r    = i_q_data.mid_r;
                sel_last = 1'b0;
            end
            PH_MAIN: begin
                sel_l    = i_q_data.cur_l;
                sel_r    = i_q_data.cur_r;
                sel_last = !i_q_data.has_tail;
            end
            PH_TAIL: begin
                sel_l    = 16'd0;
                sel_r    = 16'd0;
                sel_last = 1'b1;
            end
            default: begin
                sel_l    = 16'd0;
                sel_r    = 16'd0;
                sel_last = 1'b1;
            end
        endcase
    end

    assign o_q_pop = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MID;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left  <= sel_l;
            r_right <= sel_r;
            r_last  <= sel_last;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_last  = r_last;

endmodule

[src/pcm_gain_upsample_converter.sv]
// PCM gain and 2x upsample converter.
// Slave stream: one PCM frame per request; tdata carries left_code (bits
// 15:0) and right_code (bits 31:16), tlast marks the final frame.
// Master stream: one stereo result per request; tdata carries left_out
// (bits 15:0) and right_out (bits 31:16), tlast is high on the last result
// of an input frame.
// Config channel: index 0 volume, 1 wide_samples, 2 stereo, 3 upsample;
// other indexes are ignored. Always ready; write only while idle.
// The first result of a frame passes through three front stages, the queue
// and the output register. Throughput: the front takes one frame per cycle
// unless a full queue stalls it; the back end emits one result per cycle
// while the receiver is ready, so a frame gives one result, two with
// upsampling once a stream has started (the first frame of a stream has no
// midpoint), and one more on a final frame with upsampling for the trailing zero frame.
// The front and back parts meet in a FIFO_DEPTH-entry queue; when the
// receiver stalls, the output register holds, the queue fills and then
// o_s_axis_tready drops. Reset clears the pipeline, queue and stream state
// and loads the register reset values; no clearing pass is needed.
module pcm_gain_upsample_converter
    import pgu_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    // input frames
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // left_code[15:0], right_code[31:16]
    input  logic        i_s_axis_tlast,  // final_frame
    // output results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // left_out[15:0], right_out[31:16]
    output logic        o_m_axis_tlast   // run_end
);

    t_cfg        r_cfg;
    logic        q_full, q_push, q_valid, q_pop;
    t_qent       q_wdata, q_rdata;
    logic [15:0] out_l, out_r;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume   <= VOLUME_RST;
            r_cfg.wide     <= WIDE_RST;
            r_cfg.stereo   <= STEREO_RST;
            r_cfg.upsample <= UPSAMPLE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOLUME:   r_cfg.volume   <= i_cfg_data;
                CFG_WIDE:     r_cfg.wide     <= i_cfg_data[0];
                CFG_STEREO:   r_cfg.stereo   <= i_cfg_data[0];
                CFG_UPSAMPLE: r_cfg.upsample <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    pgu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_left_code  (i_s_axis_tdata[15:0]),
        .i_right_code (i_s_axis_tdata[31:16]),
        .i_final      (i_s_axis_tlast),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    pgu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    pgu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_left    (out_l),
        .o_right   (out_r),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_r, out_l};

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import pgu_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 6;
    localparam int          RANDOM_ITEMS = 280;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 200000;
    // first register index that the block ignores
    localparam logic [7:0]  CFG_UNUSED_LO = CFG_UPSAMPLE + 8'd1;

    // one stereo result as seen on the master stream
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        run_end;
    } t_pcm_result;

    // Gain/upsample predictor and the queue of results it still owes
    class pcm_gain_model;
        logic [9:0]  volume;
        bit          wide;
        bit          stereo;
        bit          upsample;
        logic [15:0] last_left;
        logic [15:0] last_right;
        bit          in_stream;
        t_pcm_result samples_due[$];
        int          mismatches;

        function new();
            volume     = VOLUME_RST;
            wide       = WIDE_RST;
            stereo     = STEREO_RST;
            upsample   = UPSAMPLE_RST;
            last_left  = '0;
            last_right = '0;
            in_stream  = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [9:0] data);
            case (idx)
                CFG_VOLUME:   volume   = data;
                CFG_WIDE:     wide     = data[0];
                CFG_STEREO:   stereo   = data[0];
                CFG_UPSAMPLE: upsample = data[0];
                default: ;
            endcase
        endfunction

        // volume scaling, wrapped to 16 bits
        function logic [15:0] scale(logic [15:0] code);
            int prod;
            if (wide) begin
                prod = int'($signed(code)) * int'(volume) / 256;
            end else begin
                prod = (int'(code[7:0]) - 128) * int'(volume);
            end
            return prod[15:0];
        endfunction

        // cur - (cur - prev) / 2, halving toward zero
        function logic [15:0] halfway(logic [15:0] cur, logic [15:0] prv);
            int c;
            int p;
            int m;
            c = int'($signed(cur));
            p = int'($signed(prv));
            m = c - (c - p) / 2;
            return m[15:0];
        endfunction

        function void accept_frame(logic [15:0] l_code, logic [15:0] r_code, bit fin);
            logic [15:0] cl;
            logic [15:0] cr;
            bit          tail;
            cl   = scale(l_code);
            cr   = stereo ? scale(r_code) : 16'h0000;
            tail = fin && upsample;
            if (upsample && in_stream) begin
                samples_due.push_back('{left: halfway(cl, last_left),
                                        right: stereo ? halfway(cr, last_right) : 16'h0000,
                                        run_end: 1'b0});
            end
            samples_due.push_back('{left: cl, right: cr, run_end: !tail});
            if (tail) begin
                samples_due.push_back('{left: 16'h0000, right: 16'h0000, run_end: 1'b1});
            end
            // a final frame closes the stream
            if (fin) begin
                last_left  = '0;
                last_right = '0;
                in_stream  = 1'b0;
            end else begin
                last_left  = cl;
                last_right = cr;
                in_stream  = 1'b1;
            end
        endfunction

        function void check_result(logic [31:0] data, logic last);
            t_pcm_result due;
            if (samples_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result left=%0d right=%0d run_end=%0b",
                         $time, $signed(data[15:0]), $signed(data[31:16]), last);
                return;
            end
            due = samples_due.pop_front();
            if (data[15:0] !== due.left) begin
                mismatches++;
                $display("%0t: left_out expected %0d got %0d",
                         $time, $signed(due.left), $signed(data[15:0]));
            end
            if (data[31:16] !== due.right) begin
                mismatches++;
                $display("%0t: right_out expected %0d got %0d",
                         $time, $signed(due.right), $signed(data[31:16]));
            end
            if (last !== due.run_end) begin
                mismatches++;
                $display("%0t: run_end expected %0b got %0b", $time, due.run_end, last);
            end
        endfunction

        function int pending();
            return samples_due.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index     = '0;
    logic [9:0]  i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    pcm_gain_model gain_model = new();
    bit            tx_steady   = 1'b0;
    bit            rx_steady   = 1'b0;
    int            rx_wait     = 0;
    int            cycle_count = 0;

    pcm_gain_upsample_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result side: check each request, then stall while rx_wait counts down
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                gain_model.check_result(o_m_axis_tdata, o_m_axis_tlast);
                rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
            end
            if (rx_wait > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // one register write; valid stays up for a following write
    task automatic cfg_write(logic [7:0] idx, logic [9:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        gain_model.write_reg(idx, data);
    endtask

    // full register set plus a write to an index the block must ignore
    task automatic set_config(logic [9:0] vol, bit wide, bit stereo, bit up);
        cfg_write(CFG_VOLUME, vol);
        cfg_write(CFG_WIDE, {9'd0, wide});
        cfg_write(CFG_STEREO, {9'd0, stereo});
        cfg_write(CFG_UPSAMPLE, {9'd0, up});
        cfg_write(8'($urandom_range(CFG_UNUSED_LO, 255)), 10'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // one frame request after a random gap; valid is only lowered for a gap
    task automatic send_frame(logic [15:0] l_code, logic [15:0] r_code, bit fin);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r_code, l_code};
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        gain_model.accept_frame(l_code, r_code, fin);
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (gain_model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_code();
        logic [15:0] corners[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                   16'h0080, 16'h007F};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 5)];
        end
        return 16'($urandom);
    endfunction

    function automatic logic [9:0] pick_volume();
        logic [9:0] corners[7] = '{10'd0, 10'd1, 10'd255, 10'd256, 10'd257,
                                  10'd512, 10'd1023};
        if ($urandom_range(0, 2) == 0) begin
            return 10'($urandom);
        end
        return corners[$urandom_range(0, 6)];
    endfunction

    initial begin
        int random_sent;
        int burst;
        random_sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: 16-bit stereo at unity, no upsampling
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'hFFFF, 16'h0001, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1);
        drain();

        // full gain with midpoints, trailing zero frame, one-frame stream
        set_config(10'd1023, 1'b1, 1'b1, 1'b1);
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h0001, 16'hFFFF, 1'b1);
        send_frame(16'h1234, 16'hEDCB, 1'b1);
        drain();

        // zero gain, 8-bit mono with upsampling
        set_config(10'd0, 1'b0, 1'b0, 1'b1);
        send_frame(16'hFF00, 16'h00FF, 1'b0);
        send_frame(16'hAB80, 16'h5A7F, 1'b1);
        drain();

        // 8-bit mono, high byte set on the last frame; stream left open across the next change
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        set_config(10'd1023, 1'b0, 1'b0, 1'b0);
        send_frame(16'h0000, 16'hFFFF, 1'b0);
        send_frame(16'h00FF, 16'h1234, 1'b0);
        send_frame(16'h1280, 16'hFF01, 1'b0);
        drain();

        // midpoint against samples stored under the old settings
        tx_steady = 1'b0;
        set_config(10'd300, 1'b0, 1'b1, 1'b1);
        send_frame(16'hFF7F, 16'h0081, 1'b0);
        send_frame(16'h0001, 16'h00FE, 1'b1);
        drain();

        rx_steady = 1'b0;
        set_config(10'd256, 1'b1, 1'b0, 1'b1);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b1);
        drain();

        // random streams under random settings
        while (random_sent < RANDOM_ITEMS) begin
            set_config(pick_volume(), $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 2) != 0);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(8, 30);
            repeat (burst) begin
                send_frame(pick_code(), pick_code(), $urandom_range(0, 5) == 0);
            end
            random_sent += burst;
            drain();
        end

        if (gain_model.mismatches == 0 && gain_model.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
src/pgu_pkg.sv
src/pgu_front.sv
src/pgu_fifo.sv
src/pgu_back.sv
src/pcm_gain_upsample_converter.sv
test/tb_top.sv
